/* rtl/rmsd_pkg.sv */
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared widths, types and state codes for the row mean / std deviation block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmsd_pkg;

  // sample and row sizing
  localparam int SAMPLE_W = 16;
  localparam int MAX_ROW  = 4096;
  localparam int CFG_W    = 13;
  localparam int FRAC_W   = 16;
  localparam int MEAN_W   = 32;
  localparam int SD_W     = 31;
  localparam int CNT_W    = $clog2(MAX_ROW + 1);
  localparam int LOG_ROW  = $clog2(MAX_ROW);
  localparam int SUM_W    = SAMPLE_W + LOG_ROW;
  localparam int SSQ_W    = 2 * SAMPLE_W + LOG_ROW;
  localparam int CFG_RESET = 1024;

  // back end arithmetic sizing
  localparam int QLO_W  = SSQ_W / 2;
  localparam int QHI_W  = SSQ_W - QLO_W;
  localparam int MUL_W  = SUM_W;
  localparam int ACC_W  = CNT_W + SSQ_W;
  localparam int SCALE_W = 32;
  localparam int ROOT_W = (ACC_W + SCALE_W + 1) / 2;
  localparam int V_W    = 2 * ROOT_W;
  localparam int DIV_W  = (ROOT_W > SUM_W + FRAC_W) ? ROOT_W : SUM_W + FRAC_W;

  // queue between accumulator and back end
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);

  // totals of one completed row
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sum;
    logic [SSQ_W-1:0] ssq;
  } row_tot_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_MUL_SQ,
    BK_SUB,
    BK_ROOT,
    BK_DIV_SD,
    BK_OUT
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/rmsd_front.sv */
// ----------------------------------------------------------------------------
// rmsd_front
// Row accumulator: count, sum and sum of squares, one sample per cycle while the queue is not full.
// Hands the row totals to the queue on the last sample of each row.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rmsd_pkg::CFG_W-1:0]    cfg_row_length,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rmsd_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          fifo_full,
  output logic                               push,
  output rmsd_pkg::row_tot_t                 push_data
);

  localparam int EFF_W = (rmsd_pkg::CNT_W > rmsd_pkg::CFG_W) ?
                         rmsd_pkg::CNT_W : rmsd_pkg::CFG_W;

  logic [rmsd_pkg::CFG_W-1:0]      row_len_r, row_len_nxt;
  logic [rmsd_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [rmsd_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [rmsd_pkg::SSQ_W-1:0]      ssq_r, ssq_nxt;
  logic [rmsd_pkg::CNT_W-1:0]      cnt_inc;
  logic [rmsd_pkg::SUM_W-1:0]      sum_inc;
  logic [rmsd_pkg::SSQ_W-1:0]      ssq_inc;
  logic [2*rmsd_pkg::SAMPLE_W-1:0] sq;
  logic [EFF_W-1:0]                len_ext;
  logic [EFF_W-1:0]                eff_len;
  logic                            accept;
  logic                            row_end;

  // config register always writable
  assign cfg_ready = 1'b1;

  // effective row length: zero acts as one, clipped to the maximum
  always_comb begin
    len_ext = EFF_W'(row_len_r);
    if (len_ext == '0) begin
      eff_len = EFF_W'(1);
    end else if (len_ext > EFF_W'(rmsd_pkg::MAX_ROW)) begin
      eff_len = EFF_W'(rmsd_pkg::MAX_ROW);
    end else begin
      eff_len = len_ext;
    end
  end

  // accumulate
  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign sq       = in_sample * in_sample;
  assign cnt_inc  = cnt_r + 1'b1;
  assign sum_inc  = sum_r + rmsd_pkg::SUM_W'(in_sample);
  assign ssq_inc  = ssq_r + rmsd_pkg::SSQ_W'(sq);
  assign row_end  = accept && (EFF_W'(cnt_inc) >= eff_len);

  // row totals to the queue
  assign push          = row_end;
  assign push_data.n   = cnt_inc;
  assign push_data.sum = sum_inc;
  assign push_data.ssq = ssq_inc;

  // next state
  always_comb begin
    row_len_nxt = row_len_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    ssq_nxt     = ssq_r;
    if (cfg_valid) begin
      row_len_nxt = cfg_row_length;
    end
    if (row_end) begin
      cnt_nxt = '0;
      sum_nxt = '0;
      ssq_nxt = '0;
    end else if (accept) begin
      cnt_nxt = cnt_inc;
      sum_nxt = sum_inc;
      ssq_nxt = ssq_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= rmsd_pkg::CFG_W'(rmsd_pkg::CFG_RESET);
      cnt_r     <= '0;
      sum_r     <= '0;
      ssq_r     <= '0;
    end else begin
      row_len_r <= row_len_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      ssq_r     <= ssq_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rmsd_fifo.sv */
// ----------------------------------------------------------------------------
// rmsd_fifo
// Short queue of completed row totals between accumulator and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire rmsd_pkg::row_tot_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output rmsd_pkg::row_tot_t      pop_data,
  output logic                    empty
);

  rmsd_pkg::row_tot_t            mem_r [rmsd_pkg::FIFO_DEPTH];
  logic [rmsd_pkg::FPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rmsd_pkg::FPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rmsd_pkg::FPTR_W:0]     fill_r, fill_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign full     = (fill_r == (rmsd_pkg::FPTR_W+1)'(rmsd_pkg::FIFO_DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/rmsd_div.sv */
// ----------------------------------------------------------------------------
// rmsd_div
// Restoring divider by the row count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rmsd_pkg::DIV_W-1:0] dividend,
  input  wire logic [rmsd_pkg::CNT_W-1:0] divisor,
  output logic                            done,
  output logic [rmsd_pkg::DIV_W-1:0]      quotient
);

  localparam int DCNT_W = $clog2(rmsd_pkg::DIV_W);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [DCNT_W-1:0]             step_r, step_nxt;
  logic [rmsd_pkg::DIV_W-1:0]    dvd_r, dvd_nxt;
  logic [rmsd_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  logic [rmsd_pkg::CNT_W-1:0]    dsr_r, dsr_nxt;
  logic [rmsd_pkg::CNT_W:0]      rem_sh;
  logic [rmsd_pkg::CNT_W:0]      rem_diff;
  logic                          ge;

  // one trial subtraction
  assign rem_sh   = {rem_r, dvd_r[rmsd_pkg::DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr_r};
  assign ge       = (rem_sh >= {1'b0, dsr_r});

  assign done     = done_r;
  assign quotient = dvd_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // quotient bits shift in where dividend bits shift out
      dvd_nxt  = {dvd_r[rmsd_pkg::DIV_W-2:0], ge};
      rem_nxt  = ge ? rem_diff[rmsd_pkg::CNT_W-1:0] : rem_sh[rmsd_pkg::CNT_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == DCNT_W'(rmsd_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

`default_nettype wire

/* rtl/rmsd_back.sv */
// ----------------------------------------------------------------------------
// rmsd_back
// Per-row sequencer: variance numerator over a shared multiplier, bitwise
// square root, mean and deviation through the divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fifo_empty,
  input  wire rmsd_pkg::row_tot_t           pop_data,
  output logic                              pop,
  output logic                              div_start,
  output logic [rmsd_pkg::DIV_W-1:0]        div_dividend,
  output logic [rmsd_pkg::CNT_W-1:0]        div_divisor,
  input  wire logic                         div_done,
  input  wire logic [rmsd_pkg::DIV_W-1:0]   div_quotient,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [rmsd_pkg::MEAN_W-1:0]       out_row_mean,
  output logic [rmsd_pkg::SD_W-1:0]         out_row_std_dev
);

  localparam int SCNT_W = $clog2(rmsd_pkg::ROOT_W);

  rmsd_pkg::back_state_t             state_r, state_nxt;
  logic [rmsd_pkg::CNT_W-1:0]        n_r, n_nxt;
  logic [rmsd_pkg::SUM_W-1:0]        s_r, s_nxt;
  logic [rmsd_pkg::SSQ_W-1:0]        q_r, q_nxt;
  logic [2*rmsd_pkg::MUL_W-1:0]      prod_r, prod_nxt;
  logic [rmsd_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [rmsd_pkg::V_W-1:0]          v_r, v_nxt;
  logic [rmsd_pkg::ROOT_W-1:0]       root_r, root_nxt;
  logic [rmsd_pkg::ROOT_W:0]         rem_r, rem_nxt;
  logic [SCNT_W-1:0]                 scnt_r, scnt_nxt;
  logic                              root_done_r, root_done_nxt;
  logic                              mean_got_r, mean_got_nxt;
  logic [rmsd_pkg::MEAN_W-1:0]       mean_r, mean_nxt;
  logic [rmsd_pkg::SD_W-1:0]         sd_r, sd_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [rmsd_pkg::MEAN_W-1:0]       out_mean_r, out_mean_nxt;
  logic [rmsd_pkg::SD_W-1:0]         out_sd_r, out_sd_nxt;

  logic [rmsd_pkg::MUL_W-1:0]        mul_a;
  logic [rmsd_pkg::MUL_W-1:0]        mul_b;
  logic [2*rmsd_pkg::MUL_W-1:0]      prod;
  logic [rmsd_pkg::ACC_W-1:0]        numer;
  logic [rmsd_pkg::ROOT_W+2:0]       rem_sh;
  logic [rmsd_pkg::ROOT_W+2:0]       trial;
  logic [rmsd_pkg::ROOT_W+2:0]       rem_diff;
  logic                              root_ge;
  logic                              out_free;
  logic                              both_ready;

  assign out_free   = !out_valid_r || !out_stall;
  assign both_ready = root_done_r && mean_got_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmsd_pkg::BK_IDLE:   if (!fifo_empty) state_nxt = rmsd_pkg::BK_MUL_LO;
      rmsd_pkg::BK_MUL_LO: state_nxt = rmsd_pkg::BK_MUL_HI;
      rmsd_pkg::BK_MUL_HI: state_nxt = rmsd_pkg::BK_MUL_SQ;
      rmsd_pkg::BK_MUL_SQ: state_nxt = rmsd_pkg::BK_SUB;
      rmsd_pkg::BK_SUB:    state_nxt = rmsd_pkg::BK_ROOT;
      rmsd_pkg::BK_ROOT:   if (both_ready) state_nxt = rmsd_pkg::BK_DIV_SD;
      rmsd_pkg::BK_DIV_SD: if (div_done) state_nxt = rmsd_pkg::BK_OUT;
      rmsd_pkg::BK_OUT:    if (out_free) state_nxt = rmsd_pkg::BK_IDLE;
      default:             state_nxt = rmsd_pkg::BK_IDLE;
    endcase
  end

  // control outputs and multiplier operand selection
  always_comb begin
    pop          = 1'b0;
    div_start    = 1'b0;
    div_dividend = rmsd_pkg::DIV_W'(root_r);
    mul_a        = '0;
    mul_b        = '0;
    case (state_r)
      rmsd_pkg::BK_IDLE: begin
        pop = !fifo_empty;
      end
      rmsd_pkg::BK_MUL_LO: begin
        mul_a = rmsd_pkg::MUL_W'(n_r);
        mul_b = rmsd_pkg::MUL_W'(q_r[rmsd_pkg::QLO_W-1:0]);
      end
      rmsd_pkg::BK_MUL_HI: begin
        mul_a = rmsd_pkg::MUL_W'(n_r);
        mul_b = rmsd_pkg::MUL_W'(q_r[rmsd_pkg::SSQ_W-1:rmsd_pkg::QLO_W]);
      end
      rmsd_pkg::BK_MUL_SQ: begin
        mul_a = s_r;
        mul_b = s_r;
      end
      rmsd_pkg::BK_SUB: begin
        // mean division runs alongside the root
        div_start    = 1'b1;
        div_dividend = rmsd_pkg::DIV_W'({s_r, {rmsd_pkg::FRAC_W{1'b0}}});
      end
      rmsd_pkg::BK_ROOT: begin
        div_start = both_ready;
      end
      default: begin
      end
    endcase
  end

  assign div_divisor = n_r;
  assign prod        = mul_a * mul_b;
  assign numer       = acc_r - rmsd_pkg::ACC_W'(prod_r);

  // one square root digit: bring in two bits, try (4*root + 1)
  assign rem_sh   = {rem_r, v_r[rmsd_pkg::V_W-1 -: 2]};
  assign trial    = (rmsd_pkg::ROOT_W+3)'({root_r, 2'b01});
  assign rem_diff = rem_sh - trial;
  assign root_ge  = (rem_sh >= trial);

  // datapath registers
  always_comb begin
    n_nxt         = n_r;
    s_nxt         = s_r;
    q_nxt         = q_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    v_nxt         = v_r;
    root_nxt      = root_r;
    rem_nxt       = rem_r;
    scnt_nxt      = scnt_r;
    root_done_nxt = root_done_r;
    mean_got_nxt  = mean_got_r;
    mean_nxt      = mean_r;
    sd_nxt        = sd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_mean_nxt  = out_mean_r;
    out_sd_nxt    = out_sd_r;
    case (state_r)
      rmsd_pkg::BK_IDLE: begin
        n_nxt = pop_data.n;
        s_nxt = pop_data.sum;
        q_nxt = pop_data.ssq;
      end
      rmsd_pkg::BK_MUL_LO: begin
        prod_nxt = prod;
      end
      rmsd_pkg::BK_MUL_HI: begin
        acc_nxt  = rmsd_pkg::ACC_W'(prod_r);
        prod_nxt = prod;
      end
      rmsd_pkg::BK_MUL_SQ: begin
        acc_nxt  = acc_r + (rmsd_pkg::ACC_W'(prod_r) << rmsd_pkg::QLO_W);
        prod_nxt = prod;
      end
      rmsd_pkg::BK_SUB: begin
        // numerator scaled by 2^32 feeds the root
        v_nxt         = rmsd_pkg::V_W'(numer) << rmsd_pkg::SCALE_W;
        root_nxt      = '0;
        rem_nxt       = '0;
        scnt_nxt      = '0;
        root_done_nxt = 1'b0;
        mean_got_nxt  = 1'b0;
      end
      rmsd_pkg::BK_ROOT: begin
        if (!root_done_r) begin
          v_nxt    = v_r << 2;
          root_nxt = {root_r[rmsd_pkg::ROOT_W-2:0], root_ge};
          rem_nxt  = root_ge ? rem_diff[rmsd_pkg::ROOT_W:0] : rem_sh[rmsd_pkg::ROOT_W:0];
          scnt_nxt = scnt_r + 1'b1;
          if (scnt_r == SCNT_W'(rmsd_pkg::ROOT_W - 1)) begin
            root_done_nxt = 1'b1;
          end
        end
        if (div_done) begin
          mean_nxt     = div_quotient[rmsd_pkg::MEAN_W-1:0];
          mean_got_nxt = 1'b1;
        end
      end
      rmsd_pkg::BK_DIV_SD: begin
        if (div_done) begin
          sd_nxt = div_quotient[rmsd_pkg::SD_W-1:0];
        end
      end
      rmsd_pkg::BK_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mean_r;
          out_sd_nxt    = sd_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmsd_pkg::BK_IDLE;
      root_done_r <= 1'b0;
      mean_got_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_done_r <= root_done_nxt;
      mean_got_r  <= mean_got_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    s_r        <= s_nxt;
    q_r        <= q_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    v_r        <= v_nxt;
    root_r     <= root_nxt;
    rem_r      <= rem_nxt;
    scnt_r     <= scnt_nxt;
    mean_r     <= mean_nxt;
    sd_r       <= sd_nxt;
    out_mean_r <= out_mean_nxt;
    out_sd_r   <= out_sd_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_row_mean    = out_mean_r;
  assign out_row_std_dev = out_sd_r;

endmodule

`default_nettype wire

/* rtl/row_mean_std_dev.sv */
// Path: after its last sample a row's totals pass the queue, three multiply
//   steps, a 45-step root alongside the 45-step mean divide, then a 45-step
//   deviation divide and the output register.
// Throughput: one sample per cycle unless the queue is full; the back end
//   sequencer takes one row at a time; a 4-row queue absorbs shorter rows.
// Reset: accumulators and queue empty, row length 1024, no result valid.
// ----------------------------------------------------------------------------
// row_mean_std_dev
// Streaming per-row mean (Q16.16) and population std deviation (Q15.16).
// ----------------------------------------------------------------------------
`default_nettype none

module row_mean_std_dev (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rmsd_pkg::CFG_W-1:0]    cfg_row_length,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rmsd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rmsd_pkg::MEAN_W-1:0]        out_row_mean,
  output logic [rmsd_pkg::SD_W-1:0]          out_row_std_dev
);

  rmsd_pkg::row_tot_t            push_data;
  rmsd_pkg::row_tot_t            pop_data;
  logic                          push;
  logic                          pop;
  logic                          fifo_full;
  logic                          fifo_empty;
  logic                          div_start;
  logic                          div_done;
  logic [rmsd_pkg::DIV_W-1:0]    div_dividend;
  logic [rmsd_pkg::CNT_W-1:0]    div_divisor;
  logic [rmsd_pkg::DIV_W-1:0]    div_quotient;

  // row accumulation
  rmsd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_row_length (cfg_row_length),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .fifo_full      (fifo_full),
    .push           (push),
    .push_data      (push_data)
  );

  // row totals queue
  rmsd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  // shared divider
  rmsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // per-row statistics
  rmsd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_empty      (fifo_empty),
    .pop_data        (pop_data),
    .pop             (pop),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_done        (div_done),
    .div_quotient    (div_quotient),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_mean    (out_row_mean),
    .out_row_std_dev (out_row_std_dev)
  );

endmodule

`default_nettype wire

/* sim/row_mean_std_dev_tb.sv */
// ----------------------------------------------------------------------------
// row_mean_std_dev_tb
// Self-checking bench for the row mean / std deviation block. A queue-fed
// driver streams samples under several idling patterns, a monitor folds each
// accepted sample into a local predictor and checks every row result in order.
// ----------------------------------------------------------------------------
module row_mean_std_dev_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 12;
  localparam int SETTLE_CYCLES  = 250;
  localparam int BIG_ROW        = 1000;
  localparam int RANDOM_SAMPLES = 700;
  localparam int MIN_PHASES     = 4;
  localparam int REPORT_LIMIT   = 10;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam logic [rmsd_pkg::SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef struct packed {
    logic [rmsd_pkg::MEAN_W-1:0] mean;
    logic [rmsd_pkg::SD_W-1:0]   std_dev;
  } row_stats_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_EXTREMES,
    SHAPE_FLAT,
    SHAPE_NARROW,
    SHAPE_HIGH,
    SHAPE_LOW,
    SHAPE_MOSTLY_MAX
  } row_shape_t;

  // block ports
  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          cfg_valid      = 1'b0;
  logic                          cfg_ready;
  logic [rmsd_pkg::CFG_W-1:0]    cfg_row_length = '0;
  logic                          in_valid       = 1'b0;
  logic                          in_stall;
  logic [rmsd_pkg::SAMPLE_W-1:0] in_sample      = '0;
  logic                          out_valid;
  logic                          out_stall      = 1'b0;
  logic [rmsd_pkg::MEAN_W-1:0]   out_row_mean;
  logic [rmsd_pkg::SD_W-1:0]     out_row_std_dev;

  // stimulus and checking state
  logic [rmsd_pkg::SAMPLE_W-1:0] sample_queue[$];
  row_stats_t                    row_expect[$];
  logic                          sample_taken = 1'b0;
  int                            send_idle_pct = 0;
  int                            recv_idle_pct = 0;
  int                            mismatches    = 0;
  int                            rows_checked  = 0;
  int                            samples_taken = 0;
  int                            cfg_writes    = 0;

  // predictor copy of the register and accumulators
  logic [rmsd_pkg::CFG_W-1:0]    row_len_reg = rmsd_pkg::CFG_W'(rmsd_pkg::CFG_RESET);
  logic [rmsd_pkg::CNT_W-1:0]    acc_count   = '0;
  logic [rmsd_pkg::SUM_W-1:0]    acc_sum     = '0;
  logic [rmsd_pkg::SSQ_W-1:0]    acc_sumsq   = '0;

  row_mean_std_dev dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_row_length  (cfg_row_length),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_mean    (out_row_mean),
    .out_row_std_dev (out_row_std_dev)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("status: fail");
    $finish;
  end

  // floor(sqrt(v * 2^32)), one result bit per step from the top
  function automatic logic [63:0] root_q32(input logic [63:0] v);
    logic [127:0] target;
    logic [127:0] trial_sq;
    logic [63:0]  root;
    logic [63:0]  trial;
    int           b;
    target = {64'd0, v} << 32;
    root   = '0;
    for (b = 46; b >= 0; b--) begin
      trial    = root | (64'd1 << b);
      trial_sq = {64'd0, trial} * {64'd0, trial};
      if (trial_sq <= target) root = trial;
    end
    return root;
  endfunction

  // fold one sample into the row totals, close the row when it is full
  task automatic take_sample(input logic [rmsd_pkg::SAMPLE_W-1:0] s);
    logic [63:0] eff_len;
    logic [63:0] wide_s;
    logic [63:0] count;
    logic [63:0] sum_w;
    logic [63:0] ssq_w;
    logic [63:0] mean;
    logic [63:0] numer;
    logic [63:0] sd;
    row_stats_t  want;
    wide_s  = 64'(s);
    eff_len = 64'(row_len_reg);
    if (eff_len == 64'd0) eff_len = 64'd1;
    if (eff_len > 64'(rmsd_pkg::MAX_ROW)) eff_len = 64'(rmsd_pkg::MAX_ROW);
    acc_count = acc_count + 1'b1;
    acc_sum   = acc_sum + rmsd_pkg::SUM_W'(s);
    acc_sumsq = acc_sumsq + rmsd_pkg::SSQ_W'(wide_s * wide_s);
    count     = 64'(acc_count);
    if (count >= eff_len) begin
      sum_w = 64'(acc_sum);
      ssq_w = 64'(acc_sumsq);
      mean  = (sum_w << rmsd_pkg::FRAC_W) / count;
      numer = count * ssq_w - sum_w * sum_w;
      sd    = root_q32(numer) / count;
      want.mean    = mean[rmsd_pkg::MEAN_W-1:0];
      want.std_dev = sd[rmsd_pkg::SD_W-1:0];
      row_expect.push_back(want);
      acc_count = '0;
      acc_sum   = '0;
      acc_sumsq = '0;
    end
  endtask

  // driver: next sample once the current transaction has gone, random stalls
  always @(negedge clk) begin
    if (rst_n && (!in_valid || sample_taken)) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        in_sample <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: accepted samples, register writes and row results
  always @(posedge clk) begin : monitor
    row_stats_t want;
    if (!rst_n) begin
      sample_taken <= 1'b0;
      row_len_reg  = rmsd_pkg::CFG_W'(rmsd_pkg::CFG_RESET);
      acc_count    = '0;
      acc_sum      = '0;
      acc_sumsq    = '0;
    end else begin
      sample_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        take_sample(in_sample);
        samples_taken++;
      end
      if (cfg_valid && cfg_ready) row_len_reg = cfg_row_length;
      if (out_valid && !out_stall) begin
        rows_checked++;
        if (row_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected row result: mean %h std_dev %h",
                     out_row_mean, out_row_std_dev);
        end else begin
          want = row_expect.pop_front();
          if (out_row_mean !== want.mean || out_row_std_dev !== want.std_dev) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("row %0d: mean exp %h got %h, std_dev exp %h got %h",
                       rows_checked, want.mean, out_row_mean,
                       want.std_dev, out_row_std_dev);
          end
        end
      end
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 84;
        recv_idle_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_idle_pct = 84;
      end
      default: begin
        send_idle_pct = 11;
        recv_idle_pct = 11;
      end
    endcase
  endtask

  // register write transaction, only issued while the block is idle
  task automatic write_row_length(input logic [rmsd_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_row_length <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // all samples sent, all rows returned, then let the back end settle
  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid || row_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_row(input int count, input row_shape_t shape);
    logic [rmsd_pkg::SAMPLE_W-1:0] base;
    logic [rmsd_pkg::SAMPLE_W-1:0] v;
    int                            k;
    base = rmsd_pkg::SAMPLE_W'($urandom);
    for (k = 0; k < count; k++) begin
      case (shape)
        SHAPE_UNIFORM:  v = rmsd_pkg::SAMPLE_W'($urandom);
        SHAPE_EXTREMES: v = ($urandom_range(1) != 0) ? SAMPLE_MAX : '0;
        SHAPE_FLAT:     v = base;
        SHAPE_NARROW:   v = base + rmsd_pkg::SAMPLE_W'($urandom_range(3));
        SHAPE_HIGH:     v = SAMPLE_MAX - rmsd_pkg::SAMPLE_W'($urandom_range(255));
        SHAPE_LOW:      v = rmsd_pkg::SAMPLE_W'($urandom_range(15));
        default:        v = ($urandom_range(7) == 0) ? '0 : SAMPLE_MAX;
      endcase
      sample_queue.push_back(v);
    end
  endtask

  // stimulus
  initial begin : stimulus
    int len;
    int eff_len;
    int rows;
    int r;
    int phase;
    int budget;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // partial row at the reset length, then the length lowered under it
    set_idle(IDLE_NONE);
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'h0001);
    wait_drained();
    write_row_length(13'd2);
    sample_queue.push_back(16'h8000);
    // widest spread and a flat maximum pair
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'hFFFF);
    wait_drained();

    // single-sample rows, then a zero length behaving as one
    write_row_length(13'd1);
    sample_queue.push_back(16'hAAAA);
    sample_queue.push_back(16'h5555);
    sample_queue.push_back(16'h0000);
    wait_drained();
    write_row_length(13'd0);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'h0007);
    wait_drained();

    // short odd-length rows
    write_row_length(13'd3);
    sample_queue.push_back(16'h0001);
    sample_queue.push_back(16'h0002);
    sample_queue.push_back(16'h0004);
    wait_drained();
    write_row_length(13'd5);
    sample_queue.push_back(16'd12345);
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'd40000);
    sample_queue.push_back(16'h0001);
    wait_drained();

    // all-ones length saturates to the longest row, so a long row of large
    // samples stays open until the length is lowered under it
    write_row_length('1);
    queue_row(BIG_ROW, SHAPE_MOSTLY_MAX);
    wait_drained();
    write_row_length(13'd1);
    sample_queue.push_back(16'hFFFF);
    wait_drained();

    // random phases: new length and idling pattern each time, some rows
    // left open so the next length lands mid-row
    budget = 0;
    phase  = 0;
    while (budget < RANDOM_SAMPLES || phase < MIN_PHASES) begin
      set_idle(idle_mode_t'(phase % 4));
      case ($urandom_range(9))
        0:       len = 1;
        1:       len = 0;
        2:       len = $urandom_range(2, 4);
        3, 4, 5: len = $urandom_range(5, 24);
        6, 7:    len = $urandom_range(25, 120);
        default: len = $urandom_range(121, 240);
      endcase
      write_row_length(rmsd_pkg::CFG_W'(len));
      eff_len = (len == 0) ? 1 : len;
      rows    = (eff_len > 120) ? 1 : $urandom_range(1, 240 / eff_len);
      for (r = 0; r < rows; r++)
        queue_row(eff_len, row_shape_t'($urandom_range(SHAPE_LOW)));
      budget += rows * eff_len;
      if (eff_len > 1 && $urandom_range(3) == 0) begin
        r = $urandom_range(1, eff_len - 1);
        queue_row(r, row_shape_t'($urandom_range(SHAPE_LOW)));
        budget += r;
      end
      wait_drained();
      phase++;
    end

    $display("%0d samples streamed, %0d row results checked, %0d row length writes",
             samples_taken, rows_checked, cfg_writes);
    $display("%0d random phases across all idling patterns, %0d mismatches",
             phase, mismatches);
    if (mismatches == 0 && row_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
